FILE: hdl/dvw_pkg.sv
`default_nettype none

package dvw_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_YEAR  = 2'd1,
    ST_BAD_DAY   = 2'd2,
    ST_BAD_MONTH = 2'd3
  } status_t;

  localparam logic [15:0] MAX_YEAR   = 16'd4097;
  localparam logic [7:0]  FEB_LEAP   = 8'd29;
  localparam logic [7:0]  MONTH_FEB  = 8'd2;
  localparam logic [7:0]  MONTH_MAR  = 8'd3;
  localparam logic [7:0]  MONTH_DEC  = 8'd12;

  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT, exact for x below 2^14
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int          RECIP_SHIFT = 17;

  // 25 * INV_25 == 1 mod 2^13: y is a multiple of 25 when y * INV_25 mod 2^13 <= DIV25_MAX
  localparam logic [12:0] INV_25    = 13'd7209;
  localparam logic [12:0] DIV25_MAX = 13'd327;

  localparam logic [2:0] MOD7 = 3'd7;

  // sakamoto month offsets, month 1 = january
  function automatic logic [2:0] month_offset(input logic [7:0] m);
    logic [2:0] r;
    case (m)
      8'd1:    r = 3'd0;
      8'd2:    r = 3'd3;
      8'd3:    r = 3'd2;
      8'd4:    r = 3'd5;
      8'd5:    r = 3'd0;
      8'd6:    r = 3'd3;
      8'd7:    r = 3'd5;
      8'd8:    r = 3'd1;
      8'd9:    r = 3'd4;
      8'd10:   r = 3'd6;
      8'd11:   r = 3'd2;
      8'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // days in a common year
  function automatic logic [7:0] month_length(input logic [7:0] m);
    logic [7:0] r;
    case (m)
      8'd2:                       r = 8'd28;
      8'd4, 8'd6, 8'd9, 8'd11:    r = 8'd30;
      default:                    r = 8'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/dvw_mod7.sv
`default_nettype none

module dvw_mod7 (
  input  wire logic [16:0] value,
  output logic      [2:0]  rem
);
  import dvw_pkg::*;

  logic [5:0] fold1;
  logic [3:0] fold2;

  // 8 == 1 mod 7, so octal digits can simply be added
  always_comb begin
    fold1 = 6'(value[2:0]) + 6'(value[5:3]) + 6'(value[8:6]) + 6'(value[11:9])
          + 6'(value[14:12]) + 6'(value[16:15]);
    fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
    if (fold2 >= 4'(MOD7)) begin
      rem = 3'(fold2 - 4'(MOD7));
    end else begin
      rem = fold2[2:0];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/date_validate_weekday.sv
`default_nettype none

// channel  | signals                                        | transaction
// date     | date_valid, date_stall, day/month/year_number  | valid & !stall
// result   | result_valid, result_stall, status/is_leap/wd  | valid & !stall
//
// three register stages: reciprocal multiplies, then sum and day checks,
// then mod-7 fold into the output register. the pipeline takes one date per
// cycle while the result side is not stalled; no state is kept between dates.
// rst clears the stage valid bits only.
// each stage holds while the stage after it is full and stalled, so a stall
// on the result side backs up to date_stall without dropping a transaction.

module date_validate_weekday (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             date_valid,
  output logic                  date_stall,
  input  wire logic [7:0]       day_of_month,
  input  wire logic [7:0]       month_number,
  input  wire logic [15:0]      year_number,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output dvw_pkg::status_t      status,
  output logic                  is_leap,
  output logic      [2:0]       weekday
);
  import dvw_pkg::*;

  // stage 1
  logic        v1;
  logic [7:0]  d1;
  logic [7:0]  m1;
  logic [15:0] y1;
  logic [15:0] yy1;
  logic [26:0] prod1;
  logic [12:0] div25_1;

  // stage 2
  logic        v2;
  logic [16:0] sum2;
  status_t     st2;
  logic        leap2;

  logic en1, en2, en3;

  logic [15:0] yy_next;
  logic [13:0] x_next;

  logic [13:0] x1;
  logic [9:0]  q100;
  logic [7:0]  q400;
  logic        div25;
  logic        leap_c;
  logic [7:0]  len_c;
  status_t     st_c;
  logic [16:0] sum_c;

  logic [2:0]  rem3;

  assign en3        = !result_valid || !result_stall;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign date_stall = !en1;

  // january and february count from the previous year, wrapping at 16 bits
  always_comb begin
    if (month_number < MONTH_MAR) begin
      yy_next = year_number - 16'd1;
    end else begin
      yy_next = year_number;
    end
    x_next = yy_next[15:2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= date_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1      <= day_of_month;
      m1      <= month_number;
      y1      <= year_number;
      yy1     <= yy_next;
      prod1   <= 27'(x_next) * 27'(RECIP_25);
      div25_1 <= 13'(year_number[12:0] * INV_25);
    end
  end

  // stage 2: weekday sum, leap year and date checks
  always_comb begin
    x1     = yy1[15:2];
    q100   = prod1[RECIP_SHIFT +: 10];
    q400   = q100[9:2];
    div25  = div25_1 <= DIV25_MAX;
    leap_c = (y1[1:0] == 2'd0) && (!div25 || (y1[3:0] == 4'd0));
    len_c  = month_length(m1);
    if (m1 == MONTH_FEB && leap_c) begin
      len_c = FEB_LEAP;
    end
    if (y1 > MAX_YEAR) begin
      st_c = ST_BAD_YEAR;
    end else if (d1 == 8'd0) begin
      st_c = ST_BAD_DAY;
    end else if (m1 == 8'd0 || m1 > MONTH_DEC) begin
      st_c = ST_BAD_MONTH;
    end else if (d1 > len_c) begin
      st_c = ST_BAD_DAY;
    end else begin
      st_c = ST_OK;
    end
    sum_c = 17'(yy1) + 17'(x1) - 17'(q100) + 17'(q400) + 17'(month_offset(m1)) + 17'(d1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sum2  <= sum_c;
      st2   <= st_c;
      leap2 <= leap_c;
    end
  end

  // stage 3: mod 7 into the output register
  dvw_mod7 u_mod7 (
    .value (sum2),
    .rem   (rem3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en3) begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      status <= st2;
      if (st2 == ST_OK) begin
        is_leap <= leap2;
        weekday <= rem3 + 3'd1;
      end else begin
        is_leap <= 1'b0;
        weekday <= 3'd0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dvw_checker.sv
`default_nettype none

module dvw_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              date_stall,
  input  wire logic              result_valid,
  input  wire logic              result_stall,
  input  wire dvw_pkg::status_t  status,
  input  wire logic              is_leap,
  input  wire logic [2:0]        weekday
);
  import dvw_pkg::*;

  // an error result carries no leap flag and no weekday
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> !is_leap && weekday == 3'd0)
    else $error("error result with nonzero leap or weekday");

  // a good date always has a weekday in 1..7
  a_ok_weekday: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_OK |-> weekday != 3'd0)
    else $error("valid date without weekday");

  // reset leaves no result valid
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status)
      && $stable(is_leap) && $stable(weekday))
    else $error("stalled result changed");

  // a free output side never pushes back on the input for long
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !result_stall ##1 !result_stall |-> !date_stall)
    else $error("input stalled while output drains");

endmodule

bind date_validate_weekday dvw_checker u_dvw_checker (
  .clk          (clk),
  .rst          (rst),
  .date_stall   (date_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .is_leap      (is_leap),
  .weekday      (weekday)
);

`default_nettype wire
